### rtl/teabm_pkg.sv
// ----------------------------------------------------------------------------
// teabm_pkg
// Shared types, constants and the TEA mixing function for the masked TEA
// block cipher.
// ----------------------------------------------------------------------------
package teabm_pkg;

	localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned IDX_LSB = 2;

	typedef enum logic [2:0] {
		REG_KEY0    = 3'd0,
		REG_KEY1    = 3'd1,
		REG_KEY2    = 3'd2,
		REG_KEY3    = 3'd3,
		REG_MASK_EN = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	typedef struct packed {
		logic        dec;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} blk_t;

	typedef struct packed {
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} rsp_t;

	function automatic logic [31:0] mix(input logic [31:0] w, input logic [31:0] sum,
		input logic [31:0] ka, input logic [31:0] kb);
		return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
	endfunction

endpackage

### rtl/teabm_if.sv
// ----------------------------------------------------------------------------
// teabm_req_if / teabm_rsp_if
// Valid/ready channels carrying cipher requests and processed blocks.
// ----------------------------------------------------------------------------
interface teabm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] first_word;
	logic [31:0] second_word;
	logic        last_block;

	modport source (output valid, output req_type, output first_word,
		output second_word, output last_block, input ready);
	modport sink (input valid, input req_type, input first_word,
		input second_word, input last_block, output ready);
endinterface

interface teabm_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_first_word;
	logic [31:0] out_second_word;
	logic        out_last_block;

	modport source (output valid, output out_first_word, output out_second_word,
		output out_last_block, input ready);
	modport sink (input valid, input out_first_word, input out_second_word,
		input out_last_block, output ready);
endinterface

### rtl/teabm_round_cell.sv
// ----------------------------------------------------------------------------
// teabm_round_cell
// One TEA half-round with its own pipeline register. The cell updates one
// word of the block from the other, adding on encryption and subtracting
// on decryption, with the round sums fixed at elaboration.
// ----------------------------------------------------------------------------
module teabm_round_cell #(
	parameter logic [31:0] SUM_ENC   = 32'h9e37_79b9,
	parameter logic [31:0] SUM_DEC   = 32'hc6ef_3720,
	parameter bit          EVEN_HALF = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  teabm_pkg::key_t   keys,
	input  logic              in_valid,
	input  teabm_pkg::blk_t   in_blk,
	output logic              out_valid,
	output teabm_pkg::blk_t   out_blk
);

	logic            valid_q;
	teabm_pkg::blk_t blk_q;
	teabm_pkg::blk_t blk_next;
	logic            upd_y;
	logic [31:0]     src;
	logic [31:0]     tgt;
	logic [31:0]     ka;
	logic [31:0]     kb;
	logic [31:0]     sum;
	logic [31:0]     m;
	logic [31:0]     res;

	always_comb begin
		upd_y    = in_blk.dec ? !EVEN_HALF : EVEN_HALF;
		src      = upd_y ? in_blk.z : in_blk.y;
		tgt      = upd_y ? in_blk.y : in_blk.z;
		ka       = upd_y ? keys.k0 : keys.k2;
		kb       = upd_y ? keys.k1 : keys.k3;
		sum      = in_blk.dec ? SUM_DEC : SUM_ENC;
		m        = teabm_pkg::mix(src, sum, ka, kb);
		res      = in_blk.dec ? (tgt - m) : (tgt + m);
		blk_next = in_blk;
		if (upd_y) begin
			blk_next.y = res;
		end else begin
			blk_next.z = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_q <= blk_next;
		end
	end

	assign out_valid = valid_q;
	assign out_blk   = blk_q;

endmodule

### rtl/tea_block_cipher_with_byte_mask_top.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_with_byte_mask_top
// Each request passes through one register per half-round cell, then the
// output register. Throughput: one block per cycle unless stalled; a two-entry
// output buffer lets requests keep entering while a result waits to be taken,
// until the skid entry is full and a finished block reaches the chain's end.
// Reset clears all valid flags and the key words; the mask enable resets to 1.
// ----------------------------------------------------------------------------
module tea_block_cipher_with_byte_mask_top #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [teabm_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	teabm_req_if.sink                       req,
	teabm_rsp_if.source                     rsp
);

	localparam int unsigned CELLS = 2 * ROUND_COUNT;

	teabm_pkg::key_t     key_q;
	logic                mask_en_q;
	logic [31:0]         mask_word;
	teabm_pkg::reg_idx_t idx;
	logic                en;
	logic                stg_valid [0:CELLS];
	teabm_pkg::blk_t     stg_blk   [0:CELLS];
	logic                push;
	logic                pop;
	teabm_pkg::rsp_t     push_data;
	logic                out_valid_q;
	teabm_pkg::rsp_t     out_data_q;
	logic                skid_valid_q;
	teabm_pkg::rsp_t     skid_data_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign idx    = teabm_pkg::reg_idx_t'(paddr[teabm_pkg::IDX_LSB +: 3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			mask_en_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (idx)
				teabm_pkg::REG_KEY0:    key_q.k0  <= pwdata;
				teabm_pkg::REG_KEY1:    key_q.k1  <= pwdata;
				teabm_pkg::REG_KEY2:    key_q.k2  <= pwdata;
				teabm_pkg::REG_KEY3:    key_q.k3  <= pwdata;
				teabm_pkg::REG_MASK_EN: mask_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			teabm_pkg::REG_KEY0:    prdata = key_q.k0;
			teabm_pkg::REG_KEY1:    prdata = key_q.k1;
			teabm_pkg::REG_KEY2:    prdata = key_q.k2;
			teabm_pkg::REG_KEY3:    prdata = key_q.k3;
			teabm_pkg::REG_MASK_EN: prdata = {31'd0, mask_en_q};
			default:                prdata = '0;
		endcase
	end

	assign mask_word = mask_en_q ? {4{key_q.k0[7:0]}} : 32'd0;

	// The whole chain moves unless a finished block has nowhere to go.
	assign en        = !(stg_valid[CELLS] && skid_valid_q);
	assign req.ready = en;

	assign stg_valid[0] = req.valid;
	assign stg_blk[0]   = '{
		dec:  req.req_type,
		y:    req.first_word ^ (req.req_type ? mask_word : 32'd0),
		z:    req.second_word ^ (req.req_type ? mask_word : 32'd0),
		last: req.last_block
	};

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		localparam logic [31:0] SUM_ENC = 32'(teabm_pkg::TEA_DELTA * (g / 2 + 1));
		localparam logic [31:0] SUM_DEC = 32'(teabm_pkg::TEA_DELTA * (ROUND_COUNT - g / 2));
		localparam bit          EVEN    = ((g % 2) == 0);

		teabm_round_cell #(
			.SUM_ENC   (SUM_ENC),
			.SUM_DEC   (SUM_DEC),
			.EVEN_HALF (EVEN)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.keys      (key_q),
			.in_valid  (stg_valid[g]),
			.in_blk    (stg_blk[g]),
			.out_valid (stg_valid[g+1]),
			.out_blk   (stg_blk[g+1])
		);
	end

	// Output register with a skid entry behind it.
	assign push = stg_valid[CELLS] && en;
	assign pop  = out_valid_q && rsp.ready;

	always_comb begin
		push_data.y    = stg_blk[CELLS].y ^ (stg_blk[CELLS].dec ? 32'd0 : mask_word);
		push_data.z    = stg_blk[CELLS].z ^ (stg_blk[CELLS].dec ? 32'd0 : mask_word);
		push_data.last = stg_blk[CELLS].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_data;
				end
			end else begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.out_first_word  = out_data_q.y;
	assign rsp.out_second_word = out_data_q.z;
	assign rsp.out_last_block  = out_data_q.last;

endmodule

### rtl/teabm_checker.sv
// ----------------------------------------------------------------------------
// teabm_checker
// Port-level checks on the request and result channels of the masked TEA
// block, bound to the top level.
// ----------------------------------------------------------------------------
module teabm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_first_word,
	input logic [31:0] out_second_word,
	input logic        out_last_block
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first_word)
			&& $stable(out_second_word) && $stable(out_last_block))
		else $error("result changed while stalled");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("requests refused with no result waiting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("requests refused without a stalled result");

	a_idle_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !$past(!arst_n))
		else $error("request refused straight after reset");

endmodule

bind tea_block_cipher_with_byte_mask_top teabm_checker u_teabm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (req.valid),
	.in_ready        (req.ready),
	.out_valid       (rsp.valid),
	.out_ready       (rsp.ready),
	.out_first_word  (rsp.out_first_word),
	.out_second_word (rsp.out_second_word),
	.out_last_block  (rsp.out_last_block)
);
